>>> rtl/core/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, constants and the state transition table of the pulse decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    localparam int CODE_BITS_DEF = 32;
    localparam int BIT_COUNT_W   = 6;
    localparam int CODE_W        = 32;
    localparam int COUNT_W       = 8;
    localparam int DELAY_W       = 8;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [3:0] {
        ST_INIT   = 4'd0,
        ST_FLOW   = 4'd1,
        ST_FHIGH  = 4'd2,
        ST_REPEAT = 4'd3,
        ST_PRESS  = 4'd4,
        ST_PREBIT = 4'd5,
        ST_BIT0   = 4'd6,
        ST_BIT1   = 4'd7,
        ST_IDLE0  = 4'd8,
        ST_IDLE1  = 4'd9,
        ST_IDLE2  = 4'd10,
        ST_ERROR  = 4'd11
    } state_t;

    typedef enum logic [1:0] {
        EV_PRESSED  = 2'd0,
        EV_REPEAT   = 2'd1,
        EV_RELEASED = 2'd2,
        EV_PROGRESS = 2'd3
    } event_kind_t;

    typedef enum logic {
        CMD_EDGE     = 1'b0,
        CMD_OVERFLOW = 1'b1
    } command_t;

    typedef struct packed {
        logic               level;
        logic [DELAY_W-1:0] t_early;
        state_t             n_early;
        logic [DELAY_W-1:0] t_short;
        state_t             n_short;
        logic [DELAY_W-1:0] t_long;
        state_t             n_long;
        state_t             n_late;
        state_t             n_ovf;
    } row_t;

    // one decoded item: a first result and an optional progress result
    typedef struct packed {
        logic               two;
        event_kind_t        kind0;
        logic [CODE_W-1:0]  code0;
        logic [COUNT_W-1:0] count0;
        logic [COUNT_W-1:0] count1;
    } job_t;

    function automatic row_t get_row(state_t s);
        row_t r;
        unique case (s)
            ST_INIT:   r = '{1'b0, 8'd255, ST_FLOW,  8'd0,   ST_ERROR,  8'd0,   ST_ERROR,
                             ST_ERROR, ST_INIT};
            ST_FLOW:   r = '{1'b1, 8'd18,  ST_ERROR, 8'd72,  ST_FHIGH,  8'd255, ST_ERROR,
                             ST_ERROR, ST_ERROR};
            ST_FHIGH:  r = '{1'b0, 8'd6,   ST_ERROR, 8'd13,  ST_REPEAT, 8'd26,  ST_PRESS,
                             ST_ERROR, ST_ERROR};
            ST_REPEAT: r = '{1'b1, 8'd0,   ST_ERROR, 8'd4,   ST_IDLE0,  8'd255, ST_ERROR,
                             ST_ERROR, ST_ERROR};
            ST_PRESS:  r = '{1'b1, 8'd0,   ST_ERROR, 8'd4,   ST_PREBIT, 8'd255, ST_ERROR,
                             ST_ERROR, ST_ERROR};
            ST_PREBIT: r = '{1'b0, 8'd0,   ST_ERROR, 8'd4,   ST_BIT0,   8'd12,  ST_BIT1,
                             ST_ERROR, ST_ERROR};
            ST_BIT0:   r = '{1'b1, 8'd0,   ST_ERROR, 8'd4,   ST_PREBIT, 8'd255, ST_ERROR,
                             ST_ERROR, ST_ERROR};
            ST_BIT1:   r = '{1'b1, 8'd0,   ST_ERROR, 8'd4,   ST_PREBIT, 8'd255, ST_ERROR,
                             ST_ERROR, ST_ERROR};
            ST_IDLE0:  r = '{1'b0, 8'd80,  ST_ERROR, 8'd240, ST_FLOW,   8'd255, ST_ERROR,
                             ST_ERROR, ST_IDLE1};
            ST_IDLE1:  r = '{1'b0, 8'd70,  ST_ERROR, 8'd210, ST_FLOW,   8'd255, ST_IDLE2,
                             ST_ERROR, ST_IDLE2};
            ST_IDLE2:  r = '{1'b0, 8'd255, ST_FLOW,  8'd0,   ST_ERROR,  8'd0,   ST_ERROR,
                             ST_ERROR, ST_IDLE2};
            default:   r = '{1'b0, 8'd255, ST_FLOW,  8'd0,   ST_ERROR,  8'd0,   ST_ERROR,
                             ST_ERROR, ST_INIT};
        endcase
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 8'd1;
    endfunction

endpackage

>>> rtl/core/ir_remote_pulse_decoder_top.sv
// path: a result is registered in the job queue and then in the output register before it is on
// m_tvalid; the second result of a repeat or release-plus-tick pair is loaded when the first is taken
// throughput: one input transaction per cycle while the two-entry job queue has room;
// the output register sends one result per cycle while m_tready is high, so a two-result item goes out in turn
// reset: rst_n low clears the decoder to the init state with all counts and codes zero,
// and empties the job queue and the output register
// ----------------------------------------------------------------------------
// ir_remote_pulse_decoder_top
// Remote control pulse train decoder with a decoupled decode front and result back end.
// ----------------------------------------------------------------------------
module ir_remote_pulse_decoder_top #(
    parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // delay[7:0], pin_level[8], zero[15:9]
    input  logic        s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // code[31:0], count[39:32]
    output logic [1:0]  m_tuser,  // event_kind
    output logic        m_tlast
);

    irpd_pkg::job_t        push_job;
    irpd_pkg::job_t        pop_job;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    irpd_pkg::event_kind_t out_kind;

    irpd_front #(
        .CODE_BITS (CODE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .command   (s_tuser),
        .delay     (s_tdata[7:0]),
        .pin_level (s_tdata[8]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    irpd_queue #(
        .WIDTH ($bits(irpd_pkg::job_t)),
        .DEPTH (irpd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_job),
        .pop       (q_pop),
        .pop_data  (pop_job),
        .full      (q_full),
        .empty     (q_empty)
    );

    irpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (out_kind),
        .out_code  (m_tdata[31:0]),
        .out_count (m_tdata[39:32]),
        .out_last  (m_tlast)
    );

    assign m_tuser = out_kind;

endmodule

>>> rtl/core/irpd_queue.sv
// ----------------------------------------------------------------------------
// irpd_queue
// Small register queue between the decode front and the result back end.
// ----------------------------------------------------------------------------
module irpd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
    localparam logic [PtrW-1:0] LastPtr  = PtrW'(DEPTH - 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  fill_reg, fill_next;

    assign full     = (fill_reg == DepthCnt);
    assign empty    = (fill_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/irpd_front.sv
// ----------------------------------------------------------------------------
// irpd_front
// Takes edge and overflow transactions, walks the state table, runs the entry
// actions and queues the results each item produces.
// ----------------------------------------------------------------------------
module irpd_front #(
    parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic [irpd_pkg::DELAY_W-1:0] delay,
    input  logic                         pin_level,
    input  logic                         q_full,
    output logic                         q_push,
    output irpd_pkg::job_t               q_job
);

    localparam int BcW = irpd_pkg::BIT_COUNT_W;
    localparam int CW  = irpd_pkg::CODE_W;
    localparam logic [BcW-1:0] CodeBitsCnt = BcW'(CODE_BITS);

    irpd_pkg::state_t                 state_reg, state_next;
    logic [CODE_BITS-1:0]             shift_reg, shift_next;
    logic [BcW-1:0]                   bit_count_reg, bit_count_next;
    logic [CODE_BITS-1:0]             held_reg, held_next;
    logic [irpd_pkg::COUNT_W-1:0]     repeat_reg, repeat_next;
    logic [irpd_pkg::COUNT_W-1:0]     tick_reg, tick_next;

    irpd_pkg::row_t   row;
    irpd_pkg::state_t ns;
    logic             act;
    logic             accept;
    logic             held_any;
    logic [CODE_BITS-1:0] shifted;
    logic [BcW-1:0]   bc_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign row      = irpd_pkg::get_row(state_reg);
    assign held_any = (held_reg != '0);
    assign shifted  = {(ns == irpd_pkg::ST_BIT1), shift_reg[CODE_BITS-1:1]};
    assign bc_inc   = bit_count_reg + 1'b1;

    // ignored edges leave everything as it is
    always_comb
    begin
        act = 1'b1;
        ns  = row.n_late;
        if (command == irpd_pkg::CMD_OVERFLOW)
        begin
            ns = row.n_ovf;
        end
        else if (pin_level != row.level)
        begin
            act = 1'b0;
        end
        else if (delay <= row.t_early)
        begin
            ns = row.n_early;
        end
        else if (delay <= row.t_short)
        begin
            ns = row.n_short;
        end
        else if (delay <= row.t_long)
        begin
            ns = row.n_long;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        bit_count_next = bit_count_reg;
        held_next      = held_reg;
        repeat_next    = repeat_reg;
        tick_next      = tick_reg;
        q_push         = 1'b0;
        q_job          = '0;
        if (accept && act)
        begin
            state_next = ns;
            case (ns)
                irpd_pkg::ST_INIT:
                begin
                    q_push       = 1'b1;
                    q_job.kind0  = irpd_pkg::EV_PROGRESS;
                    q_job.count0 = tick_reg;
                    tick_next    = irpd_pkg::sat_inc(tick_reg);
                end
                irpd_pkg::ST_FLOW:
                begin
                    bit_count_next = '0;
                    shift_next     = '0;
                end
                irpd_pkg::ST_REPEAT:
                begin
                    q_push       = 1'b1;
                    q_job.two    = 1'b1;
                    q_job.kind0  = irpd_pkg::EV_REPEAT;
                    q_job.code0  = CW'(held_reg);
                    q_job.count1 = repeat_reg;
                    repeat_next  = irpd_pkg::sat_inc(repeat_reg);
                end
                irpd_pkg::ST_PRESS, irpd_pkg::ST_ERROR:
                begin
                    if (held_any)
                    begin
                        q_push       = 1'b1;
                        q_job.kind0  = irpd_pkg::EV_RELEASED;
                        q_job.code0  = CW'(held_reg);
                        q_job.count0 = repeat_reg;
                        held_next    = '0;
                        repeat_next  = '0;
                        tick_next    = '0;
                    end
                end
                irpd_pkg::ST_BIT0, irpd_pkg::ST_BIT1:
                begin
                    shift_next     = shifted;
                    bit_count_next = bc_inc;
                    if (bc_inc == CodeBitsCnt)
                    begin
                        q_push      = 1'b1;
                        q_job.kind0 = irpd_pkg::EV_PRESSED;
                        q_job.code0 = CW'(shifted);
                        held_next   = shifted;
                        state_next  = irpd_pkg::ST_IDLE0;
                    end
                end
                irpd_pkg::ST_IDLE2:
                begin
                    bit_count_next = '0;
                    shift_next     = '0;
                    q_push         = 1'b1;
                    if (held_any)
                    begin
                        // release first, then a tick from the freshly cleared count
                        q_job.two    = 1'b1;
                        q_job.kind0  = irpd_pkg::EV_RELEASED;
                        q_job.code0  = CW'(held_reg);
                        q_job.count0 = repeat_reg;
                        q_job.count1 = '0;
                        held_next    = '0;
                        repeat_next  = '0;
                        tick_next    = irpd_pkg::COUNT_W'(1);
                    end
                    else
                    begin
                        q_job.kind0  = irpd_pkg::EV_PROGRESS;
                        q_job.count0 = tick_reg;
                        tick_next    = irpd_pkg::sat_inc(tick_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= irpd_pkg::ST_INIT;
            shift_reg     <= '0;
            bit_count_reg <= '0;
            held_reg      <= '0;
            repeat_reg    <= '0;
            tick_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            shift_reg     <= shift_next;
            bit_count_reg <= bit_count_next;
            held_reg      <= held_next;
            repeat_reg    <= repeat_next;
            tick_reg      <= tick_next;
        end
    end

endmodule

>>> rtl/core/irpd_back.sv
// ----------------------------------------------------------------------------
// irpd_back
// Unpacks queued items into one or two results and drives the output register.
// ----------------------------------------------------------------------------
module irpd_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  irpd_pkg::job_t               q_job,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output irpd_pkg::event_kind_t        out_kind,
    output logic [irpd_pkg::CODE_W-1:0]  out_code,
    output logic [irpd_pkg::COUNT_W-1:0] out_count,
    output logic                         out_last
);

    logic                         valid_reg, valid_next;
    logic                         second_reg, second_next;
    logic [irpd_pkg::COUNT_W-1:0] second_count_reg, second_count_next;
    irpd_pkg::event_kind_t        kind_reg, kind_next;
    logic [irpd_pkg::CODE_W-1:0]  code_reg, code_next;
    logic [irpd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         last_reg, last_next;
    logic                         load;

    assign load      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_code  = code_reg;
    assign out_count = count_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        valid_next        = valid_reg;
        second_next       = second_reg;
        second_count_next = second_count_reg;
        kind_next         = kind_reg;
        code_next         = code_reg;
        count_next        = count_reg;
        last_next         = last_reg;
        q_pop             = 1'b0;
        if (load)
        begin
            priority if (second_reg)
            begin
                valid_next  = 1'b1;
                kind_next   = irpd_pkg::EV_PROGRESS;
                code_next   = '0;
                count_next  = second_count_reg;
                last_next   = 1'b1;
                second_next = 1'b0;
            end
            else if (!q_empty)
            begin
                q_pop             = 1'b1;
                valid_next        = 1'b1;
                kind_next         = q_job.kind0;
                code_next         = q_job.code0;
                count_next        = q_job.count0;
                last_next         = !q_job.two;
                second_next       = q_job.two;
                second_count_next = q_job.count1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        second_count_reg <= second_count_next;
        kind_reg         <= kind_next;
        code_reg         <= code_next;
        count_reg        <= count_next;
        last_reg         <= last_next;
    end

endmodule

>>> rtl/core/irpd_checker.sv
// ----------------------------------------------------------------------------
// irpd_checker
// Port-level checks on the result stream of the pulse decoder.
// ----------------------------------------------------------------------------
module irpd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // a repeat is never the final result of its item
    a_repeat_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == irpd_pkg::EV_REPEAT |-> !m_tlast)
        else $error("repeat result marked last");

    // the progress count follows a repeat right away
    a_repeat_then_progress: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser == irpd_pkg::EV_REPEAT
            |=> m_tvalid && m_tuser == irpd_pkg::EV_PROGRESS && m_tlast)
        else $error("repeat not followed by its progress count");

    a_progress_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == irpd_pkg::EV_PROGRESS |-> m_tdata[31:0] == 32'd0)
        else $error("progress result carries a code");

    a_press_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == irpd_pkg::EV_PRESSED || m_tuser == irpd_pkg::EV_REPEAT)
            |-> m_tdata[39:32] == 8'd0)
        else $error("press or repeat result carries a count");

endmodule

bind ir_remote_pulse_decoder_top irpd_checker u_irpd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
